### src/vpt_pkg.sv
// Package for the particle table unit: word types, opcodes, register map.
// No dependencies.
package vpt_pkg;

  localparam int unsigned Slots = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned PosW = 20;
  localparam int unsigned GravW = 12;
  localparam int unsigned PaddrW = 4;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FORCE  = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_GRAB_RADIUS = 2'd1,
    REG_X_LIMIT = 2'd2,
    REG_Y_LIMIT = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic [IdxW-1:0]        point_index;
    logic [PosW-1:0]        add_x;
    logic [PosW-1:0]        add_y;
    logic                   add_moving;
    logic signed [PosW-1:0] force_x;
    logic signed [PosW-1:0] force_y;
    logic [PosW-1:0]        pointer_x;
    logic [PosW-1:0]        pointer_y;
    logic                   pointer_down;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0] slot_index;
    logic            table_full;
    logic [PosW-1:0] new_x;
    logic [PosW-1:0] new_y;
    logic            is_grabbed;
  } out_word_t;

  // one entry: cur x/y, prev x/y, acc x/y
  localparam int unsigned EntW = 6 * PosW;

endpackage

### src/vpt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module vpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### src/verlet_point_table_unit.sv
// Verlet particle table: 64 slots of position, previous position and force.
// Depends on vpt_pkg and vpt_ram.
// Each word passes through accept (idle), entry read, compute/write-back and
// output states, and the result waits in output for out_ready. One word in
// flight: a new word is accepted only after the result is taken, set by the
// entry RAM read-modify-write loop. Async active-low reset resets flags, grab
// state and registers; entry RAM content is undefined until added.
module verlet_point_table_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  vpt_pkg::in_word_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output vpt_pkg::out_word_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vpt_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import vpt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_OUT} state_e;

  state_e state_q;
  in_word_t req_q;
  logic [IdxW-1:0] slot_q;
  logic full_q, ok_q;
  logic [Slots-1:0] active_q, moving_q;
  logic grab_valid_q;
  logic [IdxW-1:0] grab_index_q;
  logic signed [GravW-1:0] gravity_q;
  logic [PosW-1:0] grab_radius_q, x_limit_q, y_limit_q;
  out_word_t out_q, out_d;

  // config port
  assign pready = 1'b1;
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_GRAVITY:     prdata = 32'(unsigned'(gravity_q));
      REG_GRAB_RADIUS: prdata = 32'(grab_radius_q);
      REG_X_LIMIT:     prdata = 32'(x_limit_q);
      REG_Y_LIMIT:     prdata = 32'(y_limit_q);
      default:         prdata = '0;
    endcase
  end

  // first free slot (priority encode)
  logic [IdxW-1:0] free_idx;
  logic free_found;
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = IdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  // entry RAM
  logic ram_we;
  logic [EntW-1:0] ram_wdata, ram_rdata;
  vpt_ram #(.Width(EntW), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  logic [PosW-1:0] cx, cy, qx, qy;
  logic signed [PosW-1:0] ax0, ay0;
  assign {cx, cy, qx, qy, ax0, ay0} = ram_rdata;

  // exec datapath
  logic signed [PosW+1:0] dx, dy;
  logic [2*PosW+1:0] d2, r2;
  logic mov, grab_now, gv_d, mine;
  logic signed [PosW+2:0] ay_g, ax_n, ay_n;
  logic signed [PosW+3:0] sx, sy;
  logic [PosW-1:0] nx, ny;
  logic signed [PosW+1:0] fx, fy;
  logic signed [PosW-1:0] fxs, fys;

  function automatic logic signed [PosW-1:0] sat(input logic signed [PosW+2:0] v);
    if (v > (PosW+3)'(signed'(524287))) sat = PosW'(524287);
    else if (v < -(PosW+3)'(524288)) sat = PosW'(-524288);
    else sat = v[PosW-1:0];
  endfunction

  function automatic logic [PosW-1:0] clampp(input logic signed [PosW+3:0] v,
                                             input logic [PosW-1:0] lim);
    if (v < 0) clampp = '0;
    else if (v > signed'({4'd0, lim})) clampp = lim;
    else clampp = v[PosW-1:0];
  endfunction

  always_comb begin
    mov = moving_q[slot_q];
    dx = signed'({2'b0, req_q.pointer_x}) - signed'({2'b0, cx});
    dy = signed'({2'b0, req_q.pointer_y}) - signed'({2'b0, cy});
    d2 = (2*PosW+2)'(dx * dx) + (2*PosW+2)'(dy * dy);
    r2 = (2*PosW+2)'(grab_radius_q * grab_radius_q);
    grab_now = 1'b0;
    gv_d = grab_valid_q;
    if (req_q.pointer_down && !grab_valid_q && mov) begin
      grab_now = d2 < r2;
      gv_d = grab_now;
    end else if (!req_q.pointer_down) begin
      gv_d = 1'b0;
    end
    mine = gv_d && (grab_now ? 1'b1 : grab_index_q == slot_q);
    ax_n = (PosW+3)'(ax0);
    ay_n = (PosW+3)'(ay0);
    ay_g = (PosW+3)'(ay0) + (PosW+3)'(gravity_q);
    if (mov) begin
      ay_n = (PosW+3)'(sat(ay_g));
      if (mine) begin
        ax_n = (PosW+3)'(dx >>> 1);
        ay_n = (PosW+3)'(dy >>> 1);
      end
    end
    sx = (PosW+4)'(2 * signed'((PosW+4)'(cx)) - signed'((PosW+4)'(qx))
                   + (PosW+4)'(ax_n));
    sy = (PosW+4)'(2 * signed'((PosW+4)'(cy)) - signed'((PosW+4)'(qy))
                   + (PosW+4)'(ay_n));
    nx = clampp(sx, x_limit_q);
    ny = clampp(sy, y_limit_q);
    fx = (PosW+2)'(ax0) + (PosW+2)'(req_q.force_x);
    fy = (PosW+2)'(ay0) + (PosW+2)'(req_q.force_y);
    fxs = sat((PosW+3)'(fx));
    fys = sat((PosW+3)'(fy));
    ram_we = 1'b0;
    ram_wdata = ram_rdata;
    if (state_q == ST_EXEC && ok_q) begin
      case (req_q.operation)
        OP_FORCE: begin
          ram_we = 1'b1;
          ram_wdata = {cx, cy, qx, qy, fxs, fys};
        end
        OP_UPDATE: begin
          ram_we = 1'b1;
          ram_wdata = {nx, ny, cx, cy, {PosW{1'b0}}, {PosW{1'b0}}};
        end
        default: ;
      endcase
    end
    if (state_q == ST_READ && req_q.operation == OP_ADD && !full_q) begin
      ram_we = 1'b1;
      ram_wdata = {req_q.add_x, req_q.add_y, req_q.add_x, req_q.add_y,
                   {PosW{1'b0}}, {PosW{1'b0}}};
    end
  end

  // result word, registered at the end of exec
  always_comb begin
    out_d = '0;
    out_d.slot_index = slot_q;
    case (req_q.operation)
      OP_ADD: begin
        out_d.table_full = full_q;
        if (!full_q) begin
          out_d.new_x = req_q.add_x;
          out_d.new_y = req_q.add_y;
          out_d.is_grabbed = grab_valid_q && grab_index_q == slot_q;
        end
      end
      OP_FORCE: begin
        if (ok_q) begin
          out_d.new_x = cx;
          out_d.new_y = cy;
          out_d.is_grabbed = grab_valid_q && grab_index_q == slot_q;
        end
      end
      OP_UPDATE: begin
        if (ok_q) begin
          out_d.new_x = nx;
          out_d.new_y = ny;
          out_d.is_grabbed = mine;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      req_q <= '0;
      out_q <= '0;
      active_q <= '0;
      moving_q <= '1;
      grab_valid_q <= 1'b0;
      grab_index_q <= '0;
      gravity_q <= GravW'(128);
      grab_radius_q <= PosW'(4096);
      x_limit_q <= PosW'(204800);
      y_limit_q <= PosW'(153600);
      slot_q <= '0;
      full_q <= 1'b0;
      ok_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_GRAVITY:     gravity_q <= pwdata[GravW-1:0];
          REG_GRAB_RADIUS: grab_radius_q <= pwdata[PosW-1:0];
          REG_X_LIMIT:     x_limit_q <= pwdata[PosW-1:0];
          REG_Y_LIMIT:     y_limit_q <= pwdata[PosW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            state_q <= ST_READ;
            if (in_data_i.operation == OP_ADD) begin
              slot_q <= free_idx;
              full_q <= !free_found;
            end else begin
              slot_q <= in_data_i.point_index;
              full_q <= 1'b0;
            end
            ok_q <= active_q[in_data_i.point_index];
          end
        end
        ST_READ: begin
          state_q <= ST_EXEC;
          if (req_q.operation == OP_ADD && !full_q) begin
            active_q[slot_q] <= 1'b1;
            moving_q[slot_q] <= req_q.add_moving;
          end
        end
        ST_EXEC: begin
          state_q <= ST_OUT;
          out_q <= out_d;
          case (req_q.operation)
            OP_REMOVE: begin
              if (ok_q) begin
                active_q[slot_q] <= 1'b0;
                if (grab_valid_q && grab_index_q == slot_q) grab_valid_q <= 1'b0;
              end
            end
            OP_UPDATE: begin
              if (ok_q) begin
                grab_valid_q <= gv_d;
                if (grab_now) grab_index_q <= slot_q;
              end
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

### tb/verlet_point_table_unit_tb.sv
// Testbench for verlet_point_table_unit: random and directed table operations,
// checked word by word against a behavioral predictor. Depends on vpt_pkg and verlet_point_table_unit.
`timescale 1ns / 100ps
module verlet_point_table_unit_tb;
  import vpt_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  verlet_point_table_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic signed [GravW-1:0] grav;
  logic [PosW-1:0] grab_rad, xlim, ylim;
  logic [PosW-1:0] px_cur [Slots], py_cur [Slots], px_old [Slots], py_old [Slots];
  logic signed [PosW-1:0] fx_acc [Slots], fy_acc [Slots];
  logic pt_moving [Slots], pt_live [Slots];
  logic held;
  logic [IdxW-1:0] held_idx;

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int errors = 0;
  bit quiet = 0;        // no idling in the last part
  int hold_cycles = 0;  // long receiver hold-off, counted by the monitor
  bit hold_done = 0;
  int idle_in = 0, idle_out = 0;
  int stall_cnt = 0;

  function automatic logic signed [PosW-1:0] sat20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[PosW-1:0];
  endfunction

  function automatic logic [PosW-1:0] clamp_lim(longint v, logic [PosW-1:0] lim);
    if (v < 0) return '0;
    if (v > longint'(lim)) return lim;
    return v[PosW-1:0];
  endfunction

  function automatic longint halve(longint d);
    return d >>> 1;  // arithmetic shift is floor division by two
  endfunction

  // one table operation: update state, return the predicted word
  function automatic out_word_t step_table(in_word_t w);
    out_word_t r;
    int s;
    logic [IdxW-1:0] i;
    logic ok, mine;
    longint cx, cy, ptx, pty, vx, vy, ax, ay, dx, dy;
    longint unsigned d2, r2;
    i = w.point_index;
    ok = pt_live[i];
    r = '0;
    r.slot_index = i;
    case (op_e'(w.operation))
      OP_ADD: begin
        s = -1;
        for (int k = Slots - 1; k >= 0; k--) if (!pt_live[k]) s = k;
        if (s >= 0) begin
          px_cur[s] = w.add_x; px_old[s] = w.add_x;
          py_cur[s] = w.add_y; py_old[s] = w.add_y;
          fx_acc[s] = '0; fy_acc[s] = '0;
          pt_moving[s] = w.add_moving;
          pt_live[s] = 1'b1;
          r.slot_index = s[IdxW-1:0];
          r.new_x = w.add_x; r.new_y = w.add_y;
          r.is_grabbed = held && held_idx == s[IdxW-1:0];
        end else begin
          r.slot_index = '0;
          r.table_full = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (ok) begin
          pt_live[i] = 1'b0;
          if (held && held_idx == i) held = 1'b0;
        end
      end
      OP_FORCE: begin
        if (ok) begin
          fx_acc[i] = sat20(longint'(fx_acc[i]) + longint'(w.force_x));
          fy_acc[i] = sat20(longint'(fy_acc[i]) + longint'(w.force_y));
          r.new_x = px_cur[i]; r.new_y = py_cur[i];
          r.is_grabbed = held && held_idx == i;
        end
      end
      default: begin
        if (ok) begin
          cx = longint'(px_cur[i]); cy = longint'(py_cur[i]);
          ptx = longint'(w.pointer_x); pty = longint'(w.pointer_y);
          vx = cx - longint'(px_old[i]);
          vy = cy - longint'(py_old[i]);
          if (w.pointer_down && !held && pt_moving[i]) begin
            dx = ptx - cx; dy = pty - cy;
            d2 = longint'(dx * dx) + longint'(dy * dy);
            r2 = longint'(grab_rad) * longint'(grab_rad);
            if (d2 < r2) begin
              held = 1'b1; held_idx = i;
            end
          end else if (!w.pointer_down) begin
            held = 1'b0;
          end
          mine = held && held_idx == i;
          ax = longint'(fx_acc[i]); ay = longint'(fy_acc[i]);
          if (pt_moving[i]) begin
            ay = longint'(sat20(ay + longint'(grav)));
            if (mine) begin
              ax = halve(ptx - cx);
              ay = halve(pty - cy);
            end
          end
          px_old[i] = cx[PosW-1:0]; py_old[i] = cy[PosW-1:0];
          px_cur[i] = clamp_lim(cx + vx + ax, xlim);
          py_cur[i] = clamp_lim(cy + vy + ay, ylim);
          fx_acc[i] = '0; fy_acc[i] = '0;
          r.new_x = px_cur[i]; r.new_y = py_cur[i];
          r.is_grabbed = mine;
        end
      end
    endcase
    return r;
  endfunction

  // driver: pops pending words, idles in random bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      idle_in <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (idle_in > 0) begin
          idle_in <= idle_in - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          idle_in <= $urandom_range(1, 5) - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data <= pending_words[0];
          expected_words.push_back(step_table(pending_words[0]));
          void'(pending_words.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each accepted result with the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_out <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, out_data);
          errors++;
        end else begin
          if (out_data !== expected_words[0]) begin
            $display("%0t: mismatch, expected %p, actual %p",
                     $time, expected_words[0], out_data);
            errors++;
          end
          void'(expected_words.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && pending_words.size() > 150) begin
        // long hold-off while the sender has plenty queued
        hold_done <= 1'b1;
        hold_cycles <= 199;
        out_ready <= 1'b0;
      end else if (idle_out > 0) begin
        idle_out <= idle_out - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_out <= $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      stall_cnt <= 0;
    else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 20000) begin
        $display("** verlet_point_table_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_e r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PaddrW'(4 * int'(r)); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_GRAVITY:     grav = v[GravW-1:0];
      REG_GRAB_RADIUS: grab_rad = v[PosW-1:0];
      REG_X_LIMIT:     xlim = v[PosW-1:0];
      default:         ylim = v[PosW-1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_words.size() > 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w.operation    = 2'($urandom_range(0, 3));
    w.point_index  = IdxW'($urandom_range(0, Slots - 1));
    w.add_x        = PosW'($urandom);
    w.add_y        = PosW'($urandom);
    w.add_moving   = $urandom_range(0, 3) != 0;
    w.force_x      = PosW'($urandom);
    w.force_y      = PosW'($urandom);
    w.pointer_x    = PosW'($urandom);
    w.pointer_y    = PosW'($urandom);
    w.pointer_down = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // word for a live slot, mostly near-pointer updates so grabs happen
  function automatic in_word_t live_word(int live_slot);
    in_word_t w;
    w = rand_word();
    w.point_index = IdxW'(live_slot);
    if ($urandom_range(0, 2) != 0) begin
      w.pointer_x = PosW'(px_cur[live_slot] + $urandom_range(0, 6000) - 3000);
      w.pointer_y = PosW'(py_cur[live_slot] + $urandom_range(0, 6000) - 3000);
    end
    if ($urandom_range(0, 1)) w.operation = OP_UPDATE;
    if (w.operation == OP_ADD && $urandom_range(0, 1)) w.operation = OP_FORCE;
    if ($urandom_range(0, 3) != 0) begin
      w.force_x = $signed(w.force_x) >>> $urandom_range(0, 19);
      w.force_y = $signed(w.force_y) >>> $urandom_range(0, 19);
    end
    return w;
  endfunction

  // stimulus for one phase; only live slots or add/remove words may be emitted
  task automatic gen_phase(int n);
    in_word_t w;
    int sel;
    // shadow liveness so queued words never read a never-written entry
    logic shadow [Slots];
    for (int k = 0; k < Slots; k++) shadow[k] = pt_live[k];
    for (int j = 0; j < n; j++) begin
      sel = $urandom_range(Slots - 1, 0);
      if ($urandom_range(0, 9) < 7) begin
        for (int k = 0; k < Slots && !shadow[sel]; k++) sel = (sel + 1) % Slots;
      end
      w = shadow[sel] ? live_word(sel) : rand_word();
      w.point_index = IdxW'(sel);
      if (!shadow[sel] && w.operation != OP_ADD) w.operation = OP_ADD;
      if (w.operation == OP_ADD) begin
        for (int k = 0; k < Slots; k++)
          if (!shadow[k]) begin
            shadow[k] = 1'b1;
            break;
          end
      end else if (w.operation == OP_REMOVE) begin
        if ($urandom_range(0, 2) != 0) w.operation = OP_UPDATE;
        else shadow[sel] = 1'b0;
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    in_word_t w;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    grav = 12'sd128; grab_rad = 20'd4096; xlim = 20'd204800; ylim = 20'd153600;
    held = 1'b0; held_idx = '0;
    for (int k = 0; k < Slots; k++) begin
      pt_live[k] = 1'b0; pt_moving[k] = 1'b1;
      px_cur[k] = '0; py_cur[k] = '0; px_old[k] = '0; py_old[k] = '0;
      fx_acc[k] = '0; fy_acc[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed: extremes, grab attempt, saturation, clamp, full table, remove
    w = '0;
    w.operation = OP_ADD; w.add_x = 20'd1000; w.add_y = 20'd1000; w.add_moving = 1;
    pending_words.push_back(w);
    w.add_x = '1; w.add_y = '1; w.add_moving = 0;
    pending_words.push_back(w);
    w = '0; w.operation = OP_FORCE; w.point_index = 0;
    w.force_x = 20'sd524287; w.force_y = -20'sd524288;
    pending_words.push_back(w);
    pending_words.push_back(w);  // saturates
    w = '0; w.operation = OP_UPDATE; w.point_index = 0;
    pending_words.push_back(w);  // clamp at zero on y, big x
    w.pointer_down = 1; w.pointer_x = 20'd1200; w.pointer_y = 20'd1100;
    pending_words.push_back(w);  // pointer down on slot 0, out of grab range
    pending_words.push_back(w);  // pointer stays down on slot 0
    w.point_index = 1;
    pending_words.push_back(w);  // pinned, clamped to limits
    w = '0; w.operation = OP_REMOVE; w.point_index = 0;
    pending_words.push_back(w);  // removing slot 0
    pending_words.push_back(w);  // inactive slot
    w = '0; w.operation = OP_UPDATE; w.point_index = 63;
    pending_words.push_back(w);  // addresses slot that is free
    drain();
    reg_write(REG_GRAVITY, 32'h800);
    reg_write(REG_GRAB_RADIUS, 32'hFFFFF);
    reg_write(REG_X_LIMIT, 32'h0);
    reg_write(REG_Y_LIMIT, 32'hFFFFF);
    // fill the table; the last two adds report full
    for (int k = 0; k < Slots + 1; k++) begin
      w = rand_word(); w.operation = OP_ADD;
      pending_words.push_back(w);
    end
    drain();

    // random phases with several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_GRAVITY, 32'h7FF); reg_write(REG_GRAB_RADIUS, 32'd0);
          reg_write(REG_X_LIMIT, 32'hFFFFF); reg_write(REG_Y_LIMIT, 32'd0);
        end
        5: begin
          reg_write(REG_GRAVITY, 32'd128); reg_write(REG_GRAB_RADIUS, 32'd4096);
          reg_write(REG_X_LIMIT, 32'd204800); reg_write(REG_Y_LIMIT, 32'd153600);
        end
        default: begin
          reg_write(REG_GRAVITY, $urandom); reg_write(REG_GRAB_RADIUS, $urandom_range(0, 9000));
          reg_write(REG_X_LIMIT, $urandom); reg_write(REG_Y_LIMIT, $urandom);
        end
      endcase
      // remove a few slots so adds find room
      for (int k = 0; k < Slots; k++)
        if (pt_live[k] && $urandom_range(0, 2) == 0) begin
          w = '0; w.operation = OP_REMOVE; w.point_index = IdxW'(k);
          pending_words.push_back(w);
        end
      drain();
      if (ph == 5) quiet = 1;
      gen_phase(300);
      drain();
    end

    if (errors == 0 && expected_words.size() == 0)
      $display("** verlet_point_table_unit: PASSED **");
    else
      $display("** verlet_point_table_unit: FAILED **");
    $finish;
  end
endmodule

### filelist.f
src/vpt_pkg.sv
src/vpt_ram.sv
src/verlet_point_table_unit.sv
tb/verlet_point_table_unit_tb.sv
